[rtl/core/rti_pkg.sv]
// Package for the radial table interpolator: sequencer states, field widths and table depth.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
package rti_pkg;
    localparam int COORD_W     = 24;
    localparam int DIST_W      = 24;
    localparam int VALUE_W     = 32;
    localparam int SUM_W       = 48;
    localparam int CFG_W       = 7;
    localparam int IDX_W       = 6;
    localparam int TABLE_DEPTH = 64;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_RD0,
        ST_RD1,
        ST_CMP,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;
endpackage

[rtl/core/rti_divider.sv]
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on rti_pkg.
`timescale 1ns / 1ps
module rti_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [55:0] dividend,
    input  logic [23:0] divisor,
    output logic        done,
    output logic [55:0] quotient
);
    import rti_pkg::*;

    logic [55:0] q_reg, q_next;
    logic [24:0] r_reg, r_next;
    logic [23:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] trial;
    logic [25:0] diff;

    assign trial = {r_reg[23:0], q_reg[55]};
    assign diff  = {1'b0, trial} - {2'b00, d_reg};

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 6'd55;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[25])
            begin
                r_next = diff[24:0];
                q_next = {q_reg[54:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[54:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;
endmodule

[rtl/core/radial_table_interpolator.sv]
// Radial table interpolator top level.
// A load is taken in the cycle it is offered and gives no word. An evaluate squares the
// three coordinates, takes the root in 24 steps, then reads and compares the segments in
// turn (up to 63); on a match it multiplies, divides and finishes before raising out_valid,
// on a miss it raises out_valid after the last segment. in_stall holds off new words until
// the result is taken; reset clears control, sets entries_in_use to 64 and leaves the
// tables unknown until loaded.
`timescale 1ns / 1ps
module radial_table_interpolator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rti_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [rti_pkg::IDX_W-1:0]     entry_index,
    input  logic [rti_pkg::DIST_W-1:0]    entry_distance,
    input  logic signed [rti_pkg::VALUE_W-1:0] entry_value,
    input  logic signed [rti_pkg::COORD_W-1:0] pos_x,
    input  logic signed [rti_pkg::COORD_W-1:0] pos_y,
    input  logic signed [rti_pkg::COORD_W-1:0] pos_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [rti_pkg::VALUE_W-1:0] density_value,
    output logic                          in_range
);
    import rti_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // The two tables are memories with one registered read port each.
    logic [DIST_W-1:0]  bp_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] val_mem [TABLE_DEPTH];
    logic [DIST_W-1:0]  bp_rd_reg;
    logic [VALUE_W-1:0] val_rd_reg;
    logic [AW-1:0]      rd_addr;

    state_t state_reg, state_next;
    logic [CFG_W-1:0] eiu_reg;
    logic [1:0]  axis_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [SUM_W-1:0] sum_reg, rem_reg, root_reg;
    logic [4:0]  it_reg;
    logic [CW-1:0] seg_reg, n_lim;
    logic [DIST_W-1:0] dist_reg, lo_reg, hi_reg;
    logic signed [VALUE_W-1:0] v0_reg, v1_reg, res_reg;
    logic hit_reg, neg_reg, rd_hi_reg;
    logic [55:0] prod;
    logic [DIST_W-1:0] span;
    logic [55:0] quot;
    logic div_start, div_done;
    logic in_acc;

    // Entries beyond the table depth act as the depth itself.
    assign n_lim = ({1'b0, eiu_reg} > (CFG_W+1)'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                 : CW'(eiu_reg);

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    always_ff @(posedge clk)
    begin
        if (in_acc && operation == OP_LOAD
            && {2'b00, entry_index} < (IDX_W+2)'(TABLE_DEPTH))
        begin
            bp_mem[entry_index[AW-1:0]]  <= entry_distance;
            val_mem[entry_index[AW-1:0]] <= entry_value;
        end
        bp_rd_reg  <= bp_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
    end

    // With rd_hi_reg low the base entry of the segment is read, with it high the next one.
    assign rd_addr = rd_hi_reg ? AW'(seg_reg + CW'(1)) : AW'(seg_reg);

    // Shared squaring multiplier: one axis per cycle, on the magnitude of the coordinate.
    logic signed [COORD_W-1:0] sq_in;
    logic [COORD_W-1:0] sq_mag;
    logic [SUM_W-1:0] sq_out;
    always_comb
    begin
        unique case (axis_reg)
            2'd0: sq_in = px_reg;
            2'd1: sq_in = py_reg;
            default: sq_in = pz_reg;
        endcase
    end
    assign sq_mag = sq_in[COORD_W-1] ? -sq_in : sq_in;
    assign sq_out = SUM_W'(sq_mag) * SUM_W'(sq_mag);

    // One step of the digit-by-digit square root (two bits per step, 24 steps).
    logic [SUM_W-1:0] bitv, trial;
    assign bitv  = SUM_W'(1) << {it_reg, 1'b0};
    assign trial = root_reg + bitv;

    // In ST_CMP the upper breakpoint of the segment sits in the read register.
    logic seg_match;
    assign seg_match = (dist_reg >= lo_reg) && (dist_reg < bp_rd_reg);
    assign span = hi_reg - lo_reg;

    logic signed [32:0] dv;
    logic [32:0] adv;
    logic [DIST_W-1:0] off;
    assign dv  = $signed({v1_reg[31], v1_reg}) - $signed({v0_reg[31], v0_reg});
    assign adv = dv[32] ? 33'(-dv) : 33'(dv);
    assign off = dist_reg - lo_reg;

    // The magnitude product feeds the divider directly when it starts.
    assign prod = 56'(off) * 56'(adv);

    rti_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (span),
        .done     (div_done),
        .quotient (quot)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc && operation == OP_EVAL) state_next = ST_SQ;
            ST_SQ:   if (axis_reg == 2'd2) state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (it_reg == 5'd0)
                    state_next = (n_lim < CW'(2)) ? ST_OUT : ST_RD0;
            end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_CMP;
            ST_CMP:
            begin
                if (seg_match) state_next = ST_MUL;
                else if (seg_reg + CW'(2) >= n_lim) state_next = ST_OUT;
                else state_next = ST_RD0;
            end
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign div_start = (state_reg == ST_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            eiu_reg   <= CFG_W'(64);
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) eiu_reg <= cfg_wdata;
            if (state_reg == ST_IDLE) hit_reg <= 1'b0;
            else if (state_reg == ST_CMP && seg_match) hit_reg <= 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                px_reg <= pos_x; py_reg <= pos_y; pz_reg <= pos_z;
                axis_reg <= 2'd0; sum_reg <= '0; root_reg <= '0;
                it_reg <= 5'd23; seg_reg <= '0; rd_hi_reg <= 1'b0;
                res_reg <= '0;
            end
            ST_SQ:
            begin
                sum_reg <= sum_reg + sq_out;
                axis_reg <= axis_reg + 2'd1;
                if (axis_reg == 2'd2) rem_reg <= sum_reg + sq_out;
            end
            ST_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bitv;
                end
                else
                    root_reg <= root_reg >> 1;
                it_reg <= it_reg - 5'd1;
                rd_hi_reg <= 1'b0;
            end
            ST_RD0: rd_hi_reg <= 1'b1;
            ST_RD1:
            begin
                lo_reg <= bp_rd_reg; v0_reg <= val_rd_reg;
                rd_hi_reg <= 1'b0;
            end
            ST_CMP:
            begin
                // The upper entry arrives in the cycle after the lower one.
                hi_reg <= bp_rd_reg; v1_reg <= val_rd_reg;
                if (!seg_match) seg_reg <= seg_reg + CW'(1);
            end
            ST_MUL:
            begin
                neg_reg <= dv[32];
            end
            ST_FIN:
                res_reg <= v0_reg + (neg_reg ? -VALUE_W'(quot) : VALUE_W'(quot));
            default: ;
        endcase
        if (state_reg == ST_SQRT && it_reg == 5'd0)
            dist_reg <= DIST_W'((rem_reg >= trial) ? (root_reg >> 1) + bitv
                                                   : root_reg >> 1);
    end

    assign out_valid     = (state_reg == ST_OUT);
    assign density_value = res_reg;
    assign in_range      = hit_reg;
endmodule

[verif/radial_table_interpolator_checker.sv]
// Checker for the radial table interpolator: watches the input and output channels,
// predicts each evaluate result from its own copy of the table, and counts mismatches.
// Depends on rti_pkg for field widths and the operation codes.
`timescale 1ns / 1ps
module radial_table_interpolator_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rti_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                operation,
    input  logic [rti_pkg::IDX_W-1:0]           entry_index,
    input  logic [rti_pkg::DIST_W-1:0]          entry_distance,
    input  logic signed [rti_pkg::VALUE_W-1:0]  entry_value,
    input  logic signed [rti_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [rti_pkg::COORD_W-1:0]  pos_y,
    input  logic signed [rti_pkg::COORD_W-1:0]  pos_z,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [rti_pkg::VALUE_W-1:0]  density_value,
    input  logic                                in_range,
    output int                                  failures,
    output int                                  pending,
    output int                                  results_seen,
    output int                                  hits_seen
);
    import rti_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      hit;
    } density_t;

    logic [DIST_W-1:0]         knot_dist [64];
    logic signed [VALUE_W-1:0] knot_val  [64];
    logic [CFG_W-1:0]          span_count;
    density_t                  expected_density [$];

    // Bitwise integer square root, floored, of a 48-bit sum of squares.
    function automatic logic [DIST_W-1:0] radius_of(logic [SUM_W:0] n);
        logic [SUM_W:0] root;
        logic [SUM_W:0] bit_w;
        root  = '0;
        bit_w = 49'd1 << 48;
        while (bit_w > n)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (n >= root + bit_w)
            begin
                n    = n - (root + bit_w);
                root = (root >> 1) + bit_w;
            end
            else
                root = root >> 1;
            bit_w = bit_w >> 2;
        end
        return root[DIST_W-1:0];
    endfunction

    function automatic density_t interpolate(logic signed [COORD_W-1:0] x,
                                             logic signed [COORD_W-1:0] y,
                                             logic signed [COORD_W-1:0] z);
        longint   sx, sy, sz, lo, hi, v0, v1, d;
        int       n;
        density_t r;
        sx = x;
        sy = y;
        sz = z;
        d  = radius_of(49'(sx * sx + sy * sy + sz * sz));
        n  = (span_count > 64) ? 64 : span_count;
        r  = '0;
        for (int i = 0; i + 1 < n; i++)
        begin
            lo = knot_dist[i];
            hi = knot_dist[i + 1];
            if (d >= lo && d < hi)
            begin
                v0 = knot_val[i];
                v1 = knot_val[i + 1];
                // SystemVerilog signed division truncates toward zero, as required.
                r.value = 32'(v0 + ((d - lo) * (v1 - v0)) / (hi - lo));
                r.hit   = 1'b1;
                break;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        density_t e;
        if (!rst_n)
        begin
            span_count = 7'd64;
            expected_density.delete();
            failures     = 0;
            results_seen = 0;
            hits_seen    = 0;
        end
        else
        begin
            if (cfg_we)
                span_count = cfg_wdata;
            if (in_valid && !in_stall)
            begin
                if (operation == OP_LOAD)
                begin
                    knot_dist[entry_index] = entry_distance;
                    knot_val[entry_index]  = entry_value;
                end
                else
                    expected_density.insert(expected_density.size(),
                                            interpolate(pos_x, pos_y, pos_z));
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (in_range)
                    hits_seen++;
                if (expected_density.size() == 0)
                begin
                    $display("%0t: unexpected word, actual value %0d in_range %0b",
                             $time, density_value, in_range);
                    failures++;
                end
                else
                begin
                    e = expected_density.pop_front();
                    if (e.value !== density_value || e.hit !== in_range)
                    begin
                        $display("%0t: mismatch, expected %0d/%0b actual %0d/%0b", $time,
                                 e.value, e.hit, density_value, in_range);
                        failures++;
                    end
                end
            end
        end
        pending = expected_density.size();
    end
endmodule

[verif/radial_table_interpolator_test.sv]
// Testbench top for the radial table interpolator: drives clock, reset, register writes
// and words, and gives the verdict. Depends on rti_pkg and radial_table_interpolator_checker.
`timescale 1ns / 1ps
module radial_table_interpolator_test;
    import rti_pkg::*;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_W-1:0]            cfg_wdata;
    logic                        in_valid;
    logic                        in_stall;
    logic                        operation;
    logic [IDX_W-1:0]            entry_index;
    logic [DIST_W-1:0]           entry_distance;
    logic signed [VALUE_W-1:0]   entry_value;
    logic signed [COORD_W-1:0]   pos_x;
    logic signed [COORD_W-1:0]   pos_y;
    logic signed [COORD_W-1:0]   pos_z;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [VALUE_W-1:0]   density_value;
    logic                        in_range;
    int                          failures;
    int                          pending;
    int                          results_seen;
    int                          hits_seen;
    int                          words_sent;
    bit                          hold_off;   // forces a long receiver stall

    radial_table_interpolator i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .entry_index    (entry_index),
        .entry_distance (entry_distance),
        .entry_value    (entry_value),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .density_value  (density_value),
        .in_range       (in_range)
    );

    radial_table_interpolator_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .entry_index    (entry_index),
        .entry_distance (entry_distance),
        .entry_value    (entry_value),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .density_value  (density_value),
        .in_range       (in_range),
        .failures       (failures),
        .pending        (pending),
        .results_seen   (results_seen),
        .hits_seen      (hits_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Gap length: mostly zero or short, now and then a long pause.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    // Offer one word after a random gap and hold it steady until the block takes it.
    // Valid stays high afterwards; the next call or the caller lowers it.
    task automatic send_word(op_t op, logic [IDX_W-1:0] idx, logic [DIST_W-1:0] brk_dist,
                             logic [VALUE_W-1:0] val, logic [COORD_W-1:0] x,
                             logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
        int gap;
        gap = gap_length();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_valid       <= 1'b1;
        operation      <= op;
        entry_index    <= idx;
        entry_distance <= brk_dist;
        entry_value    <= val;
        pos_x          <= x;
        pos_y          <= y;
        pos_z          <= z;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic eval_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z);
        send_word(OP_EVAL, IDX_W'($urandom), DIST_W'($urandom), $urandom, x, y, z);
    endtask

    // Register writes happen only with the block idle: drain, then wait out the latency.
    task automatic write_span_count(logic [CFG_W-1:0] n);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Load a full ascending table with random spacing, scaled so that the last
    // breakpoint lands at most near the given top distance, about half of it on average.
    task automatic load_table(int top);
        logic [DIST_W-1:0] d;
        d = DIST_W'($urandom_range(0, top / 128));
        for (int i = 0; i < 64; i++)
        begin
            send_word(OP_LOAD, IDX_W'(i), d, $urandom, COORD_W'($urandom),
                      COORD_W'($urandom), COORD_W'($urandom));
            d = d + DIST_W'($urandom_range(1, top / 64 + 1));
        end
    endtask

    // Random coordinate, biased toward small offsets so that most distances hit the table.
    function automatic logic [COORD_W-1:0] coordinate(int reach);
        if ($urandom_range(0, 9) == 0)
            return COORD_W'($urandom);
        return COORD_W'($urandom_range(0, 1) ? $urandom_range(0, reach)
                                             : -$urandom_range(0, reach));
    endfunction

    task automatic eval_burst(int count, int reach);
        for (int i = 0; i < count; i++)
            eval_at(coordinate(reach), coordinate(reach), coordinate(reach));
    endtask

    // Receiver: random stalls, plus one long hold-off counted here.
    initial
    begin
        int gap;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (2000)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            gap = gap_length();
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap)
                    @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        #60ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        operation      = OP_LOAD;
        entry_index    = '0;
        entry_distance = '0;
        entry_value    = '0;
        pos_x          = '0;
        pos_y          = '0;
        pos_z          = '0;
        hold_off       = 1'b0;
        words_sent     = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a table with extreme values, an empty segment and a reversed
        // segment, then evaluates at zero, at exact breakpoints and at the largest magnitudes.
        for (int i = 0; i < 64; i++)
            send_word(OP_LOAD, IDX_W'(i), 24'(i * 24'h3FFFF),
                      (i % 2) ? 32'h7FFFFFFF : 32'h80000000, '0, '0, '0);
        send_word(OP_LOAD, 6'd5, 24'(4 * 24'h3FFFF), 32'd12345, '0, '0, '0); // empty segment
        send_word(OP_LOAD, 6'd9, 24'h000010, 32'hFFFF0000, '0, '0, '0);      // reversed
        send_word(OP_LOAD, 6'd63, 24'hFFFFFF, 32'h00010000, '0, '0, '0);
        eval_at('0, '0, '0);
        eval_at(24'h3FFFF, '0, '0);
        eval_at('0, 24'h800000, '0);
        eval_at(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        eval_at(24'h800000, 24'h800000, 24'h800000);
        eval_at('0, '0, 24'hFFFFFF);
        eval_at(24'h100000, -24'sh100000, 24'h123456);
        eval_at('0, '0, 24'(10 * 24'h3FFFF));

        // One segment, then the largest register value, then no segment; then back to 64.
        write_span_count(7'd2);
        eval_at('0, '0, '0);
        eval_at(24'h20000, '0, '0);
        write_span_count(7'd127);
        eval_at(24'h55555, 24'h2AAAA, '0);
        write_span_count(7'd0);
        eval_at('0, '0, '0);
        write_span_count(7'd64);

        // Receiver holds off long while the sender keeps offering words.
        hold_off = 1'b1;
        eval_burst(6, 24'h100000);

        // Random phases: fresh tables at several scales and register settings.
        for (int phase = 0; phase < 8; phase++)
        begin
            int top;
            top = (phase % 2) ? 24'hFFFFFF : $urandom_range(24'h10000, 24'h800000);
            load_table(top);
            // A few loose loads overwrite slots with random content.
            for (int k = 0; k < 4; k++)
                send_word(OP_LOAD, IDX_W'($urandom), DIST_W'($urandom), $urandom,
                          '0, '0, '0);
            eval_burst(70, top / 2);
            write_span_count((phase == 3) ? 7'd64 : 7'($urandom_range(2, 64)));
            eval_burst(20, top / 2);
            write_span_count(7'd64);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400)
            @(posedge clk);
        $display("Sent %0d words; checked %0d results, %0d of them inside the table.",
                 words_sent, results_seen, hits_seen);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
